/* rtl/ps2_keyboard_byte_handler_macros.svh */
// Assertion helpers for the PS/2 keyboard byte handler checker.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef PS2_KEYBOARD_BYTE_HANDLER_MACROS_SVH
`define PS2_KEYBOARD_BYTE_HANDLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PS2KB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PS2KB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ps2kb_pkg.sv */
package ps2kb_pkg;

  localparam int CMD_QUEUE_DEPTH_DEF = 16;
  localparam int NUM_KEYS            = 39;
  localparam int KEY_IDX_W           = 6;

  // Bytes that the keyboard sends outside the make-code table.
  localparam logic [7:0] BYTE_ERROR_LO    = 8'h00;
  localparam logic [7:0] BYTE_ERROR_HI    = 8'hFF;
  localparam logic [7:0] BYTE_SELFTEST_OK = 8'hAA;
  localparam logic [7:0] BYTE_ECHO        = 8'hEE;
  localparam logic [7:0] BYTE_ACK         = 8'hFA;
  localparam logic [7:0] BYTE_FAIL_LO     = 8'hFC;
  localparam logic [7:0] BYTE_FAIL_HI     = 8'hFD;
  localparam logic [7:0] BYTE_RESEND      = 8'hFE;
  localparam logic [7:0] BYTE_RELEASE     = 8'hF0;

  localparam logic [7:0] MAKE_CODES [NUM_KEYS] = '{
    8'h0D, 8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h21, 8'h22,
    8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E,
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h3A, 8'h3B, 8'h3C, 8'h3D,
    8'h3E, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h4B, 8'h4D, 8'h5A
  };

  typedef enum logic [0:0] {
    KIND_RX  = 1'b0,
    KIND_CMD = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    STATUS_NONE          = 4'd0,
    STATUS_ERROR         = 4'd1,
    STATUS_SELFTEST_OK   = 4'd2,
    STATUS_ECHO          = 4'd3,
    STATUS_ACK           = 4'd4,
    STATUS_SELFTEST_FAIL = 4'd5,
    STATUS_RESEND        = 4'd6,
    STATUS_RELEASE       = 4'd7,
    STATUS_KEY_EVENT     = 4'd8,
    STATUS_CMD_QUEUED    = 4'd9,
    STATUS_CMD_DROPPED   = 4'd10
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    status_e                 status;
    logic                    key_valid;
    logic [KEY_IDX_W-1:0]    key_index;
    logic                    key_released;
    logic                    send_valid;
    logic [7:0]              send_byte;
    logic [NUM_KEYS-1:0]     keys_down;
  } out_t;

  // Classification of one input word.
  typedef struct packed {
    status_e              status;
    logic                 is_cmd;
    logic                 is_ack;
    logic                 is_resend;
    logic                 is_prefix;
    logic                 is_key;
    logic [KEY_IDX_W-1:0] key_index;
  } dec_t;

  // Requests to the command queue, already qualified by the input handshake.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       resend;
    logic [7:0] data;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic send_valid;
    logic from_ram;
  } q_rsp_t;

  typedef struct packed {
    logic                 hit;
    logic [KEY_IDX_W-1:0] index;
  } key_hit_t;

  function automatic key_hit_t key_lookup(logic [7:0] b);
    key_hit_t r;
    r.hit   = 1'b0;
    r.index = '0;
    // The codes are unique, so at most one entry matches.
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (MAKE_CODES[i] == b) begin
        r.hit   = 1'b1;
        r.index = KEY_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/ps2kb_ram.sv */
module ps2kb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ps2kb_decode.sv */
module ps2kb_decode (
  input  ps2kb_pkg::in_t  in_i,
  output ps2kb_pkg::dec_t dec_o
);
  import ps2kb_pkg::*;

  key_hit_t hit;

  assign hit = key_lookup(in_i.data_byte);

  always_comb begin
    dec_o           = '0;
    dec_o.status    = STATUS_NONE;
    dec_o.key_index = hit.index;
    if (in_i.kind == KIND_CMD) begin
      dec_o.is_cmd = 1'b1;
    end else begin
      case (in_i.data_byte)
        BYTE_ERROR_LO, BYTE_ERROR_HI: dec_o.status = STATUS_ERROR;
        BYTE_SELFTEST_OK:             dec_o.status = STATUS_SELFTEST_OK;
        BYTE_ECHO:                    dec_o.status = STATUS_ECHO;
        BYTE_ACK: begin
          dec_o.status = STATUS_ACK;
          dec_o.is_ack = 1'b1;
        end
        BYTE_FAIL_LO, BYTE_FAIL_HI:   dec_o.status = STATUS_SELFTEST_FAIL;
        BYTE_RESEND: begin
          dec_o.status    = STATUS_RESEND;
          dec_o.is_resend = 1'b1;
        end
        BYTE_RELEASE: begin
          dec_o.status    = STATUS_RELEASE;
          dec_o.is_prefix = 1'b1;
        end
        default: begin
          // An unmapped byte reports nothing and changes no state.
          if (hit.hit) begin
            dec_o.status = STATUS_KEY_EVENT;
            dec_o.is_key = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/ps2kb_cmd_queue.sv */
module ps2kb_cmd_queue #(
  parameter int CMD_QUEUE_DEPTH = ps2kb_pkg::CMD_QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ps2kb_pkg::q_req_t req_i,
  output ps2kb_pkg::q_rsp_t rsp_o,
  output logic [7:0]        rdata_o
);
  import ps2kb_pkg::*;

  localparam int PtrW = $clog2(CMD_QUEUE_DEPTH);
  localparam int CntW = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam int SumW = CntW + 1;

  logic [PtrW-1:0] head_q, head_d, head_next, tail;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] tail_sum;
  logic            empty, full, push_ok, pop_ok, re;
  logic [PtrW-1:0] raddr;

  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(CMD_QUEUE_DEPTH));

  assign head_next = (head_q == PtrW'(CMD_QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // head + count stays below twice the depth, so one subtract wraps it.
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= SumW'(CMD_QUEUE_DEPTH))
                  ? PtrW'(tail_sum - SumW'(CMD_QUEUE_DEPTH)) : PtrW'(tail_sum);

  assign push_ok = req_i.push && !full;
  assign pop_ok  = req_i.pop && !empty;

  always_comb begin
    head_d = head_q;
    count_d = count_q;
    re = 1'b0;
    raddr = head_q;
    rsp_o.full = full;
    rsp_o.send_valid = 1'b0;
    rsp_o.from_ram = 1'b0;
    if (push_ok) begin
      count_d = count_q + 1'b1;
      rsp_o.send_valid = empty;
    end else if (pop_ok) begin
      head_d  = head_next;
      count_d = count_q - 1'b1;
      if (count_q != CntW'(1)) begin
        re = 1'b1;
        raddr = head_next;
        rsp_o.send_valid = 1'b1;
        rsp_o.from_ram = 1'b1;
      end
    end else if (req_i.resend && !empty) begin
      re = 1'b1;
      rsp_o.send_valid = 1'b1;
      rsp_o.from_ram = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  ps2kb_ram #(
    .WIDTH (8),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (tail),
    .wdata_i (req_i.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_o)
  );

endmodule

/* rtl/ps2_keyboard_byte_handler.sv */
// PS/2 keyboard byte handler, scancode set 2, host side.
// Input channel (in_valid_i, in_stall_o, in_i): each word is either a byte
// received from the keyboard or a command byte to queue for transmission.
// Output channel (out_valid_o, out_stall_i, out_o): exactly one result word
// per input word, in order: status, key event, byte to send, held-key bitmap.
// A word accepted at a clock edge is registered in the decode stage, then
// in the output register, which drives out_o. One word is accepted every
// cycle while the output side takes results; the decode stage and the
// output register each hold a word, and the command store's read is registered.
// When out_stall_i is high the output register holds its word; the decode
// stage fills, and then in_stall_o rises in the same cycle, so nothing is
// lost. Reset clears the held-key bitmap, the pending release, the queue
// pointers and both stage valids; the command bytes themselves are not
// cleared and need no clearing pass.
module ps2_keyboard_byte_handler #(
  parameter int CMD_QUEUE_DEPTH = ps2kb_pkg::CMD_QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ps2kb_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ps2kb_pkg::out_t out_o
);
  import ps2kb_pkg::*;

  dec_t   dec;
  q_req_t q_req;
  q_rsp_t q_rsp;
  logic [7:0] q_rdata;

  logic accept, s2_ready, s1_adv;
  logic s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic release_pending_q, release_pending_d;
  logic [NUM_KEYS-1:0] held_keys_q, held_keys_d;
  out_t s1_q, s1_d, out_q, out_d;
  logic s1_from_ram_q;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign accept     = in_valid_i && !in_stall_o;

  ps2kb_decode u_decode (
    .in_i  (in_i),
    .dec_o (dec)
  );

  assign q_req.push   = accept && dec.is_cmd;
  assign q_req.pop    = accept && dec.is_ack;
  assign q_req.resend = accept && dec.is_resend;
  assign q_req.data   = in_i.data_byte;

  ps2kb_cmd_queue #(
    .CMD_QUEUE_DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (q_req),
    .rsp_o   (q_rsp),
    .rdata_o (q_rdata)
  );

  always_comb begin
    held_keys_d       = held_keys_q;
    release_pending_d = release_pending_q;
    if (accept) begin
      if (dec.is_prefix) begin
        release_pending_d = 1'b1;
      end else if (dec.is_key) begin
        held_keys_d[dec.key_index] = !release_pending_q;
        release_pending_d = 1'b0;
      end
    end
  end

  always_comb begin
    s1_d              = '0;
    s1_d.status       = dec.status;
    if (dec.is_cmd) begin
      s1_d.status = q_rsp.full ? STATUS_CMD_DROPPED : STATUS_CMD_QUEUED;
    end
    s1_d.key_valid    = dec.is_key;
    s1_d.key_index    = dec.is_key ? dec.key_index : '0;
    s1_d.key_released = dec.is_key && release_pending_q;
    s1_d.send_valid   = q_rsp.send_valid;
    // A byte sent straight from the input is the first one into an empty queue.
    s1_d.send_byte    = (q_rsp.send_valid && !q_rsp.from_ram) ? in_i.data_byte : '0;
    s1_d.keys_down    = held_keys_d;
  end

  always_comb begin
    out_d = s1_q;
    if (s1_from_ram_q) begin
      out_d.send_byte = q_rdata;
    end
  end

  assign s1_valid_d  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      release_pending_q <= 1'b0;
      held_keys_q       <= '0;
    end else begin
      s1_valid_q        <= s1_valid_d;
      out_valid_q       <= out_valid_d;
      release_pending_q <= release_pending_d;
      held_keys_q       <= held_keys_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q          <= s1_d;
      s1_from_ram_q <= q_rsp.from_ram;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* rtl/ps2kb_checker.sv */
`include "ps2_keyboard_byte_handler_macros.svh"

module ps2kb_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input ps2kb_pkg::out_t out_o
);
  import ps2kb_pkg::*;

  // The input side may only stall behind a held result word.
  `PS2KB_ASSERT_SAME(a_in_stall, in_stall_o, out_valid_o && out_stall_i,
    "input stalled while the output register was free to move")

  `PS2KB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_o), "result word changed while stalled")

  `PS2KB_ASSERT_SAME(a_key_status, out_valid_o,
    out_o.key_valid == (out_o.status == STATUS_KEY_EVENT),
    "key_valid disagrees with status")

  `PS2KB_ASSERT_SAME(a_send_status, out_valid_o && out_o.send_valid,
    out_o.status == STATUS_ACK || out_o.status == STATUS_RESEND ||
    out_o.status == STATUS_CMD_QUEUED, "send without ack, resend or queued command")

  `PS2KB_ASSERT_SAME(a_bitmap, out_valid_o && out_o.key_valid,
    out_o.keys_down[out_o.key_index] == !out_o.key_released,
    "held-key bitmap disagrees with key event")

endmodule

bind ps2_keyboard_byte_handler ps2kb_checker u_ps2kb_checker (.*);
